[rtl/bdeq_pkg.sv]
// Shared types and constants for the bounded double-ended queue.
// Used by the queue controller and the top level; no dependencies.
package bdeq_pkg;

  localparam int unsigned CmdW  = 3;
  localparam int unsigned DataW = 32;
  localparam int unsigned CapW  = 11;

  localparam logic [CapW-1:0]  CapReset  = 11'd1024;
  localparam logic [DataW-1:0] EmptyWord = '1;

  typedef enum logic [CmdW-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_REAR  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_REAR   = 3'd3,
    CMD_STATUS     = 3'd4
  } cmd_e;

  // Result of one command, as handed from the controller to the output stage
  typedef struct packed {
    logic              ok;
    logic [DataW-1:0]  front_value;
    logic [DataW-1:0]  rear_value;
    logic              is_empty;
    logic              is_full;
  } res_t;

endpackage

[rtl/bdeq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module bdeq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bdeq_ctrl.sv]
// Queue controller: head index, entry count, cached front and rear entries,
// and the ring memory access sequence. Depends on bdeq_pkg.
module bdeq_ctrl #(
  parameter int unsigned MaxDepth = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [bdeq_pkg::CapW-1:0]     cap_i,
  input  logic                          cmd_valid_i,
  output logic                          cmd_ready_o,
  input  logic [bdeq_pkg::CmdW-1:0]     cmd_i,
  input  logic [bdeq_pkg::DataW-1:0]    value_i,
  input  logic                          out_free_i,
  output logic                          res_valid_o,
  output bdeq_pkg::res_t                res_o,
  output logic                          ram_we_o,
  output logic [$clog2(MaxDepth)-1:0]   ram_waddr_o,
  output logic [bdeq_pkg::DataW-1:0]    ram_wdata_o,
  output logic                          ram_re_o,
  output logic [$clog2(MaxDepth)-1:0]   ram_raddr_o,
  input  logic [bdeq_pkg::DataW-1:0]    ram_rdata_i
);
  import bdeq_pkg::*;

  localparam int unsigned AW   = $clog2(MaxDepth);
  localparam int unsigned SumW = AW + 1;
  localparam int unsigned CntW = $clog2(MaxDepth + 1);
  localparam int unsigned CmpW = (CntW > CapW) ? CntW : CapW;

  localparam logic [AW-1:0]   LastSlot = AW'(MaxDepth - 1);
  localparam logic [SumW-1:0] DepthSum = SumW'(MaxDepth);
  localparam logic [CmpW-1:0] DepthCmp = CmpW'(MaxDepth);
  localparam logic [CntW-1:0] MaxCnt   = CntW'(MaxDepth);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  state_e             state_q, state_d;
  logic [AW-1:0]      head_q, head_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [DataW-1:0]   front_q, front_d;
  logic [DataW-1:0]   rear_q, rear_d;
  logic               ok_q, ok_d;
  logic               rd_front_q, rd_front_d;

  logic [CmpW-1:0]    cap_x;
  logic [CmpW-1:0]    eff_cap;
  logic               full;
  logic               empty;
  logic               accept;
  logic [AW-1:0]      head_dec;

  // (head + offset) wrapped into the ring; offset stays below MaxDepth
  function automatic logic [AW-1:0] ring_slot(logic [AW-1:0] head, logic [SumW-1:0] offset);
    logic [SumW-1:0] sum;
    sum = {1'b0, head} + offset;
    if (sum >= DepthSum) begin
      sum = sum - DepthSum;
    end
    return sum[AW-1:0];
  endfunction

  // Saturate the capacity register to 1..MaxDepth
  always_comb begin
    cap_x   = CmpW'(cap_i);
    eff_cap = cap_x;
    if (cap_x == '0) begin
      eff_cap = CmpW'(1);
    end else if (cap_x > DepthCmp) begin
      eff_cap = DepthCmp;
    end
  end

  assign full        = CmpW'(cnt_q) >= eff_cap;
  assign empty       = (cnt_q == '0);
  assign cmd_ready_o = (state_q == ST_IDLE) && out_free_i;
  assign accept      = cmd_valid_i && cmd_ready_o;
  assign head_dec    = (head_q == '0) ? LastSlot : head_q - 1'b1;
  assign ram_wdata_o = value_i;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    front_d     = front_q;
    rear_d      = rear_q;
    ok_d        = ok_q;
    rd_front_d  = rd_front_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = head_dec;
    ram_re_o    = 1'b0;
    ram_raddr_o = ring_slot(head_q, SumW'(1));
    res_valid_o = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          ok_d = 1'b0;
          case (cmd_e'(cmd_i))
            CMD_PUSH_FRONT: begin
              if (!full) begin
                head_d      = head_dec;
                cnt_d       = cnt_q + 1'b1;
                ram_we_o    = 1'b1;
                ram_waddr_o = head_dec;
                front_d     = value_i;
                if (empty) begin
                  rear_d = value_i;
                end
                ok_d = 1'b1;
              end
            end
            CMD_PUSH_REAR: begin
              if (!full) begin
                cnt_d       = cnt_q + 1'b1;
                ram_we_o    = 1'b1;
                ram_waddr_o = ring_slot(head_q, SumW'(cnt_q));
                rear_d      = value_i;
                if (empty) begin
                  front_d = value_i;
                end
                ok_d = 1'b1;
              end
            end
            CMD_POP_FRONT: begin
              if (!empty) begin
                head_d = ring_slot(head_q, SumW'(1));
                cnt_d  = cnt_q - 1'b1;
                ok_d   = 1'b1;
                // one entry left: it is the cached rear; more: fetch the new front
                if (cnt_q == CntW'(2)) begin
                  front_d = rear_q;
                end else if (cnt_q > CntW'(2)) begin
                  ram_re_o    = 1'b1;
                  ram_raddr_o = ring_slot(head_q, SumW'(1));
                  rd_front_d  = 1'b1;
                  state_d     = ST_READ;
                end
              end
            end
            CMD_POP_REAR: begin
              if (!empty) begin
                cnt_d = cnt_q - 1'b1;
                ok_d  = 1'b1;
                if (cnt_q == CntW'(2)) begin
                  rear_d = front_q;
                end else if (cnt_q > CntW'(2)) begin
                  ram_re_o    = 1'b1;
                  ram_raddr_o = ring_slot(head_q, SumW'(cnt_q - CntW'(2)));
                  rd_front_d  = 1'b0;
                  state_d     = ST_READ;
                end
              end
            end
            CMD_STATUS: begin
              ok_d = 1'b1;
            end
            default: begin
              ok_d = 1'b0;
            end
          endcase
          res_valid_o = (state_d == ST_IDLE);
        end
      end
      ST_READ: begin
        if (rd_front_q) begin
          front_d = ram_rdata_i;
        end else begin
          rear_d = ram_rdata_i;
        end
        res_valid_o = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.ok          = ok_d;
    res_o.is_empty    = (cnt_d == '0);
    res_o.is_full     = CmpW'(cnt_d) >= eff_cap;
    res_o.front_value = (cnt_d == '0) ? EmptyWord : front_d;
    res_o.rear_value  = (cnt_d == '0) ? EmptyWord : rear_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      head_q     <= '0;
      cnt_q      <= '0;
      ok_q       <= 1'b0;
      rd_front_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      head_q     <= head_d;
      cnt_q      <= cnt_d;
      ok_q       <= ok_d;
      rd_front_q <= rd_front_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q <= front_d;
    rear_q  <= rear_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt) else $error("entry count exceeds ring depth");

  a_read_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_READ |-> $past(ram_re_o)) else $error("read state without memory read");

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |-> !ram_re_o) else $error("ring write and read in the same cycle");

  a_result_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> out_free_i) else $error("result produced while output register busy");

endmodule

[rtl/bounded_double_ended_queue_top.sv]
// Bounded double-ended queue: a ring memory of MaxDepth unsigned 32-bit entries with
// a capacity register. Pushes, status commands and pops that leave at most one entry
// give their result in the cycle they are accepted; a pop that leaves two or more
// entries waits in the read state for the new front or rear entry from the ring RAM.
// The front and rear entries are cached in registers, so no other command reads the
// memory. No clearing pass is needed after reset. Results go out through an output
// register; write the capacity only while the queue is idle.
// Depends on bdeq_pkg, bdeq_ram and bdeq_ctrl.
module bounded_double_ended_queue_top #(
  parameter int unsigned MaxDepth = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bdeq_pkg::CapW-1:0]   cfg_wdata_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [31:0]                 s_axis_tdata,  // value
  input  logic [2:0]                  s_axis_tuser,  // command
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // ok, front_value, rear_value, is_empty, is_full, zero fill
  output logic [71:0]                 m_axis_tdata
);
  import bdeq_pkg::*;

  localparam int unsigned AW = $clog2(MaxDepth);

  logic [CapW-1:0]   cap_q;
  logic              out_valid_q, out_valid_d;
  res_t              out_res_q;
  logic              out_free;
  logic              res_valid;
  res_t              res;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [DataW-1:0]  ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [DataW-1:0]  ram_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CapReset;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  assign out_free = !out_valid_q || m_axis_tready;

  bdeq_ctrl #(
    .MaxDepth(MaxDepth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cap_i       (cap_q),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_i       (s_axis_tuser),
    .value_i     (s_axis_tdata),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  bdeq_ram #(
    .Width(DataW),
    .Depth(MaxDepth)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Load a fresh result, otherwise drop the valid once the item is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_res_q.is_full, out_res_q.is_empty,
                          out_res_q.rear_value, out_res_q.front_value, out_res_q.ok};

endmodule
